[rtl/pidc_pkg.sv]
// Shared types and constants for the clamped PID speed controller.
`default_nettype none
package pidc_pkg;

	localparam int SPEED_W   = 16;
	localparam int STAMP_W   = 32;
	localparam int GAIN_W    = 16;
	localparam int LEVEL_W   = 16;
	localparam int ERR_W     = 17;
	localparam int DIFF_W    = 18;
	localparam int ACC_W     = 64;
	localparam int MUL_A_W   = 18;
	localparam int MUL_B_W   = 24;
	localparam int PROD_W    = 42;
	localparam int XL_W      = 22;
	localparam int CFG_IDX_W = 3;
	localparam int CS_W      = 2;

	// register indexes on the config port
	localparam logic [CFG_IDX_W-1:0] REG_TARGET  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_P  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_I  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_D  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_MIN = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_MAX = 3'd5;

	// clamp status codes
	localparam logic [CS_W-1:0] CS_WITHIN = 2'd0;
	localparam logic [CS_W-1:0] CS_HIGH   = 2'd1;
	localparam logic [CS_W-1:0] CS_LOW    = 2'd2;

	// shared multiplier operand selects
	localparam logic [2:0] MS_ERR_DTL = 3'd0;
	localparam logic [2:0] MS_ERR_DTH = 3'd1;
	localparam logic [2:0] MS_P_LO    = 3'd2;
	localparam logic [2:0] MS_P_HI    = 3'd3;
	localparam logic [2:0] MS_I_LO    = 3'd4;
	localparam logic [2:0] MS_I_HI    = 3'd5;
	localparam logic [2:0] MS_D_LO    = 3'd6;
	localparam logic [2:0] MS_D_HI    = 3'd7;

	// product alignment in the accumulator
	localparam logic [1:0] SH_0  = 2'd0;
	localparam logic [1:0] SH_16 = 2'd1;
	localparam logic [1:0] SH_22 = 2'd2;

	// gain operand limit (2^44) and saturated product (2^60) as 2^38 << 22
	localparam logic signed [ACC_W-1:0]  TERM_LIM = 64'sh0000_1000_0000_0000;
	localparam logic signed [ACC_W-1:0]  TERM_NEG = -TERM_LIM;
	localparam logic signed [PROD_W-1:0] SAT_PROD = 42'sh040_0000_0000;

	typedef struct packed {
		logic       load_in;
		logic       start_div;
		logic       acc_clr;
		logic       mul_en;
		logic [2:0] mul_sel;
		logic       int_upd;
		logic       deriv_ld;
		logic       out_ld;
	} pidc_cmd_t;

	typedef struct packed {
		logic div_done;
	} pidc_sts_t;

endpackage
`default_nettype wire

[rtl/pidc_div.sv]
// Restoring serial divider, one quotient bit per cycle.
`default_nettype none
module pidc_div #(
	parameter int NUM_W = 33
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [NUM_W-1:0]            num,
	input  wire logic [pidc_pkg::STAMP_W-1:0] den,
	output logic [NUM_W-1:0]                 quo,
	output logic                             busy
);
	import pidc_pkg::*;

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [STAMP_W-1:0] rem_q;
	logic [NUM_W-1:0]   quo_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [STAMP_W:0]   trial;
	logic               fits;

	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign fits  = trial >= {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(NUM_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? STAMP_W'(trial - {1'b0, den}) : trial[STAMP_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end

	assign quo  = quo_q;
	assign busy = cnt_q != '0;

endmodule
`default_nettype wire

[rtl/pidc_dp.sv]
// Datapath: config registers, loop state, shared multiplier, accumulator, output register.
`default_nettype none
module pidc_dp #(
	parameter int TIME_FRAC_BITS = 16,
	parameter int INTEGRAL_WIDTH = 48
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [pidc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [15:0]                   cfg_data,
	input  wire logic [pidc_pkg::SPEED_W-1:0]   in_speed,
	input  wire logic [pidc_pkg::STAMP_W-1:0]   in_stamp,
	input  wire pidc_pkg::pidc_cmd_t            cmd,
	output pidc_pkg::pidc_sts_t                 sts,
	output logic [pidc_pkg::LEVEL_W-1:0]        pwm_level,
	output logic [pidc_pkg::CS_W-1:0]           clamp_state,
	output logic                               zero_interval
);
	import pidc_pkg::*;

	localparam int NUM_W = ERR_W + TIME_FRAC_BITS;
	localparam int DER_W = NUM_W + 1;
	localparam logic signed [ACC_W:0] INT_HI =
		(ACC_W+1)'((65'sd1 <<< (INTEGRAL_WIDTH - 1)) - 65'sd1);
	localparam logic signed [ACC_W:0] INT_LO = -INT_HI - 65'sd1;

	// configuration
	logic signed [SPEED_W-1:0] target_q;
	logic [GAIN_W-1:0]         gain_p_q, gain_i_q, gain_d_q;
	logic [LEVEL_W-1:0]        out_min_q, out_max_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q  <= '0;
			gain_p_q  <= 16'd410;
			gain_i_q  <= 16'd41;
			gain_d_q  <= 16'd41;
			out_min_q <= '0;
			out_max_q <= 16'd32768;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TARGET:  target_q  <= cfg_data;
				REG_GAIN_P:  gain_p_q  <= cfg_data;
				REG_GAIN_I:  gain_i_q  <= cfg_data;
				REG_GAIN_D:  gain_d_q  <= cfg_data;
				REG_OUT_MIN: out_min_q <= cfg_data;
				REG_OUT_MAX: out_max_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// loop state
	logic signed [ERR_W-1:0]          err_q, prev_err_q;
	logic signed [DIFF_W-1:0]         diff_q;
	logic [STAMP_W-1:0]               dt_q, prev_stamp_q;
	logic signed [INTEGRAL_WIDTH-1:0] integ_q;
	logic signed [DER_W-1:0]          deriv_q;
	logic signed [ERR_W-1:0]          err_c;

	assign err_c = ERR_W'(target_q) - ERR_W'($signed(in_speed));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_err_q   <= '0;
			prev_stamp_q <= '0;
		end else if (cmd.load_in) begin
			prev_err_q   <= err_c;
			prev_stamp_q <= in_stamp;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			err_q  <= err_c;
			diff_q <= DIFF_W'(err_c) - DIFF_W'(prev_err_q);
			dt_q   <= in_stamp - prev_stamp_q;
		end
	end

	// derivative: |diff| * 2^TIME_FRAC_BITS / dt, sign restored after
	logic [DIFF_W-1:0] diff_mag;
	logic [NUM_W-1:0]  div_num, div_quo;
	logic              div_busy;

	assign diff_mag = diff_q[DIFF_W-1] ? DIFF_W'(-diff_q) : DIFF_W'(diff_q);
	assign div_num  = {diff_mag[ERR_W-1:0], {TIME_FRAC_BITS{1'b0}}};

	pidc_div #(.NUM_W(NUM_W)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.start_div),
		.num    (div_num),
		.den    (dt_q),
		.quo    (div_quo),
		.busy   (div_busy)
	);

	assign sts.div_done = !div_busy;

	always_ff @(posedge clk) begin
		if (cmd.deriv_ld) begin
			if (dt_q == '0)
				deriv_q <= '0;
			else if (diff_q[DIFF_W-1])
				deriv_q <= -$signed({1'b0, div_quo});
			else
				deriv_q <= $signed({1'b0, div_quo});
		end
	end

	// shared multiplier operand selection
	logic signed [ACC_W-1:0]   term_x;
	logic [GAIN_W-1:0]         term_g;
	logic                      is_hi, is_dt, sat_hi, sat_lo, force_p;
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [PROD_W-1:0]  force_val, prod_c;
	logic [1:0]                sh_c;

	always_comb begin
		term_x = ACC_W'(err_q);
		term_g = gain_p_q;
		is_hi  = 1'b0;
		is_dt  = 1'b0;
		unique case (cmd.mul_sel)
			MS_ERR_DTL: is_dt = 1'b1;
			MS_ERR_DTH: begin
				is_dt = 1'b1;
				is_hi = 1'b1;
			end
			MS_P_LO: ;
			MS_P_HI: is_hi = 1'b1;
			MS_I_LO: begin
				term_x = ACC_W'(integ_q);
				term_g = gain_i_q;
			end
			MS_I_HI: begin
				term_x = ACC_W'(integ_q);
				term_g = gain_i_q;
				is_hi  = 1'b1;
			end
			MS_D_LO: begin
				term_x = ACC_W'(deriv_q);
				term_g = gain_d_q;
			end
			MS_D_HI: begin
				term_x = ACC_W'(deriv_q);
				term_g = gain_d_q;
				is_hi  = 1'b1;
			end
		endcase
	end

	always_comb begin
		sat_hi    = term_x > TERM_LIM;
		sat_lo    = term_x < TERM_NEG;
		force_p   = 1'b0;
		force_val = '0;
		if (is_dt) begin
			mul_a = {2'b00, is_hi ? dt_q[31:16] : dt_q[15:0]};
			mul_b = MUL_B_W'(err_q);
			sh_c  = is_hi ? SH_16 : SH_0;
		end else begin
			mul_a = {2'b00, term_g};
			mul_b = is_hi ? term_x[XL_W+MUL_B_W-1:XL_W] : {2'b00, term_x[XL_W-1:0]};
			sh_c  = is_hi ? SH_22 : SH_0;
			// out-of-range operand: whole term becomes +-2^60 unless gain is zero
			if (sat_hi || sat_lo) begin
				force_p = 1'b1;
				if (is_hi && term_g != '0)
					force_val = sat_hi ? SAT_PROD : -SAT_PROD;
			end
		end
	end

	assign prod_c = mul_a * mul_b;

	// product register then accumulate
	logic signed [PROD_W-1:0] prod_q;
	logic [1:0]               sh_q;
	logic                     pv_q;
	logic signed [ACC_W-1:0]  acc_q, prod_al;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pv_q <= 1'b0;
		else
			pv_q <= cmd.mul_en;
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			prod_q <= force_p ? force_val : prod_c;
			sh_q   <= sh_c;
		end
	end

	always_comb begin
		unique case (sh_q)
			SH_16:   prod_al = ACC_W'(prod_q) <<< 16;
			SH_22:   prod_al = ACC_W'(prod_q) <<< 22;
			default: prod_al = ACC_W'(prod_q);
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.acc_clr)
			acc_q <= '0;
		else if (pv_q)
			acc_q <= acc_q + prod_al;
	end

	// saturating integral update from err*dt in the accumulator
	logic signed [ACC_W-1:0] inc_c;
	logic signed [ACC_W:0]   isum_c;

	assign inc_c  = acc_q >>> TIME_FRAC_BITS;
	assign isum_c = (ACC_W+1)'(integ_q) + (ACC_W+1)'(inc_c);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q <= '0;
		end else if (cmd.int_upd) begin
			if (isum_c > INT_HI)
				integ_q <= INTEGRAL_WIDTH'(INT_HI);
			else if (isum_c < INT_LO)
				integ_q <= INTEGRAL_WIDTH'(INT_LO);
			else
				integ_q <= INTEGRAL_WIDTH'(isum_c);
		end
	end

	// level = floor(sum / 32), max tested first
	logic signed [ACC_W-1:0] level_c, lmax_c, lmin_c;
	logic [LEVEL_W-1:0]      pwm_q;
	logic [CS_W-1:0]         cs_q;
	logic                    zero_q;

	assign level_c = acc_q >>> 5;
	assign lmax_c  = $signed(ACC_W'(out_max_q));
	assign lmin_c  = $signed(ACC_W'(out_min_q));

	always_ff @(posedge clk) begin
		if (cmd.out_ld) begin
			zero_q <= dt_q == '0;
			priority if (level_c > lmax_c) begin
				pwm_q <= out_max_q;
				cs_q  <= CS_HIGH;
			end else if (level_c < lmin_c) begin
				pwm_q <= out_min_q;
				cs_q  <= CS_LOW;
			end else begin
				pwm_q <= level_c[LEVEL_W-1:0];
				cs_q  <= CS_WITHIN;
			end
		end
	end

	assign pwm_level     = pwm_q;
	assign clamp_state   = cs_q;
	assign zero_interval = zero_q;

endmodule
`default_nettype wire

[rtl/pidc_ctrl.sv]
// Controller: sequences one control tick through the datapath and owns the handshakes.
`default_nettype none
module pidc_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output pidc_pkg::pidc_cmd_t    cmd,
	input  wire pidc_pkg::pidc_sts_t sts
);
	import pidc_pkg::*;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_START = 4'd1;
	localparam logic [3:0] ST_M1    = 4'd2;
	localparam logic [3:0] ST_M2    = 4'd3;
	localparam logic [3:0] ST_INT   = 4'd4;
	localparam logic [3:0] ST_WDIV  = 4'd5;
	localparam logic [3:0] ST_T0    = 4'd6;
	localparam logic [3:0] ST_T1    = 4'd7;
	localparam logic [3:0] ST_T2    = 4'd8;
	localparam logic [3:0] ST_T3    = 4'd9;
	localparam logic [3:0] ST_T4    = 4'd10;
	localparam logic [3:0] ST_T5    = 4'd11;
	localparam logic [3:0] ST_DRAIN = 4'd12;
	localparam logic [3:0] ST_OUT   = 4'd13;

	logic [3:0] state_q, state_d;
	logic       ov_q;
	logic       out_free;

	assign out_free = !ov_q || out_ready;
	assign in_ready = state_q == ST_IDLE;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = ST_START;
				end
			end
			ST_START: begin
				cmd.start_div = 1'b1;
				cmd.acc_clr   = 1'b1;
				cmd.mul_en    = 1'b1;
				cmd.mul_sel   = MS_ERR_DTL;
				state_d       = ST_M1;
			end
			ST_M1: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MS_ERR_DTH;
				state_d     = ST_M2;
			end
			ST_M2: state_d = ST_INT;
			ST_INT: begin
				cmd.int_upd = 1'b1;
				cmd.acc_clr = 1'b1;
				state_d     = ST_WDIV;
			end
			ST_WDIV: begin
				if (sts.div_done) begin
					cmd.deriv_ld = 1'b1;
					state_d      = ST_T0;
				end
			end
			ST_T0: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MS_P_LO;
				state_d     = ST_T1;
			end
			ST_T1: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MS_P_HI;
				state_d     = ST_T2;
			end
			ST_T2: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MS_I_LO;
				state_d     = ST_T3;
			end
			ST_T3: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MS_I_HI;
				state_d     = ST_T4;
			end
			ST_T4: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MS_D_LO;
				state_d     = ST_T5;
			end
			ST_T5: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MS_D_HI;
				state_d     = ST_DRAIN;
			end
			ST_DRAIN: state_d = ST_OUT;
			ST_OUT: begin
				if (out_free) begin
					cmd.out_ld = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_ld)
				ov_q <= 1'b1;
			else if (out_ready)
				ov_q <= 1'b0;
		end
	end

	assign out_valid = ov_q;

endmodule
`default_nettype wire

[rtl/pid_speed_controller_clamped.sv]
// Top level of the clamped PID speed controller.
//
// One request on s_axis is one control tick: measured speed (Q8.8) and a
// time stamp in ticks of a 2^TIME_FRAC_BITS Hz base. Each tick gives exactly
// one request on m_axis: the Q1.15 PWM level, the clamp status and a flag
// that marks a zero interval (derivative forced to zero).
// Config writes go over the cfg channel (index, 16-bit data); cfg_ready is
// always high. The user must write registers only while the block is idle;
// the block itself does not enforce it. A new tick is not taken until the
// controller has finished computing the last one; the serial divider for
// the derivative, one quotient bit per cycle over TIME_FRAC_BITS + 17 bits,
// bounds the tick rate. The eight multiplications share one 18x24
// multiplier while the divider runs or afterwards.
// The result sits in an output register; s_axis_tready returns right after
// it is loaded, so the next tick is taken while the result waits. If the
// receiver stalls, the next finished tick waits in the controller.
// Reset clears the loop state (previous error, integral, previous stamp)
// and loads the register reset values: gains 410/41/41, clamp 0..32768.
`default_nettype none
module pid_speed_controller_clamped #(
	parameter int TIME_FRAC_BITS = 16,
	parameter int INTEGRAL_WIDTH = 48
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// tick input
	input  wire logic                          s_axis_tvalid,
	output logic                               s_axis_tready,
	input  wire logic [47:0]                   s_axis_tdata,  // [15:0] measured_speed, [47:16] time_stamp
	// result output
	output logic                               m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	output logic [15:0]                        m_axis_tdata,  // [15:0] pwm_level
	output logic [2:0]                         m_axis_tuser,  // [1:0] clamp_state, [2] zero_interval
	// register writes
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [pidc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [15:0]                   cfg_data
);
	import pidc_pkg::*;

	pidc_cmd_t          cmd;
	pidc_sts_t          sts;
	logic [LEVEL_W-1:0] pwm_level;
	logic [CS_W-1:0]    clamp_state;
	logic               zero_interval;

	assign cfg_ready = 1'b1;

	pidc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd),
		.sts       (sts)
	);

	pidc_dp #(
		.TIME_FRAC_BITS (TIME_FRAC_BITS),
		.INTEGRAL_WIDTH (INTEGRAL_WIDTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_speed      (s_axis_tdata[15:0]),
		.in_stamp      (s_axis_tdata[47:16]),
		.cmd           (cmd),
		.sts           (sts),
		.pwm_level     (pwm_level),
		.clamp_state   (clamp_state),
		.zero_interval (zero_interval)
	);

	assign m_axis_tdata = pwm_level;
	assign m_axis_tuser = {zero_interval, clamp_state};

endmodule
`default_nettype wire

[rtl/pidc_chk.sv]
// Port-level checker for the PID controller, bound to the top level.
`default_nettype none
module pidc_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [15:0] m_axis_tdata,
	input wire logic [2:0]  m_axis_tuser
);
	import pidc_pkg::*;

	// a taken tick keeps the input closed while it is worked on
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input accepted again right after a tick");

	a_valid_held: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result dropped while stalled");

	a_data_held: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result changed while stalled");

	a_clamp_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tuser[1:0] == CS_WITHIN || m_axis_tuser[1:0] == CS_HIGH
			|| m_axis_tuser[1:0] == CS_LOW)
		else $error("bad clamp status");

endmodule

bind pid_speed_controller_clamped pidc_chk u_pidc_chk (.*);
`default_nettype wire

[tb/tb_top.sv]
// Self-checking testbench for the clamped PID speed controller: directed table, then random ticks.
`timescale 1ns / 100ps
module tb_top;
	import pidc_pkg::*;

	localparam int TIME_FRAC = 16;
	localparam int INTEG_W   = 48;
	localparam int HOLD_CYCLES = 400;
	localparam int LATENCY = TIME_FRAC + 28;

	// saturation limits of the control law
	localparam longint FACTOR_LIM = 64'sh0000_1000_0000_0000;
	localparam longint PROD_LIM   = 64'sh1000_0000_0000_0000;
	localparam longint INT_HI     = (longint'(1) << (INTEG_W - 1)) - 1;
	localparam longint INT_LO     = -INT_HI - 1;
	localparam longint TICK_SCALE = longint'(1) << TIME_FRAC;

	// indexes past the register map, must be ignored
	localparam logic [CFG_IDX_W-1:0] REG_SPARE6 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE7 = 3'd7;

	localparam logic [31:0] S0 = 32'h1000_0000;

	typedef struct packed {
		logic [15:0]     level;
		logic [CS_W-1:0] cs;
		logic            zero;
	} pwm_result_t;

	localparam pwm_result_t ANY_RESULT = '0;

	typedef enum logic {ROW_WRITE, ROW_TICK} row_kind_t;

	typedef struct {
		row_kind_t             kind;
		logic [CFG_IDX_W-1:0]  idx;   // register for writes, unused on ticks
		logic [15:0]           val;   // register data or measured speed
		logic [31:0]           stamp;
		bit                    typed; // 1: want holds the result, else predicted
		pwm_result_t           want;
	} dir_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [47:0]          s_axis_tdata;  // [15:0] measured_speed, [47:16] time_stamp
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [15:0]          m_axis_tdata;  // [15:0] pwm_level
	logic [2:0]           m_axis_tuser;  // [1:0] clamp_state, [2] zero_interval
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [15:0]          cfg_data;

	// register copies
	logic signed [15:0] set_target;
	logic [15:0]        set_kp, set_ki, set_kd, set_out_min, set_out_max;

	// loop state copies
	longint      ctl_prev_err;
	longint      ctl_integral;
	logic [31:0] ctl_prev_stamp;

	pwm_result_t pending_pwm [$];
	int          fail_count;

	int src_idle_pct;
	int sink_stall_pct;
	int hold_reqs, hold_seen, hold_left;

	// First tick runs on reset gains; later zero-interval rows reuse stamp S0 so
	// only the proportional term matters and the result is plain to read.
	dir_row_t dir_rows [34] = '{
		'{ROW_TICK,  REG_TARGET,  16'hFF00, S0,           1'b0, ANY_RESULT},
		'{ROW_WRITE, REG_GAIN_I,  16'h0000, 32'd0,        1'b0, ANY_RESULT},
		'{ROW_WRITE, REG_GAIN_D,  16'h0000, 32'd0,        1'b0, ANY_RESULT},
		'{ROW_WRITE, REG_GAIN_P,  16'hFFFF, 32'd0,        1'b0, ANY_RESULT},
		'{ROW_WRITE, REG_TARGET,  16'h7FFF, 32'd0,        1'b0, ANY_RESULT},
		'{ROW_TICK,  REG_TARGET,  16'h8000, S0,           1'b1, '{16'd32768, CS_HIGH, 1'b1}},
		'{ROW_WRITE, REG_TARGET,  16'h8000, 32'd0,        1'b0, ANY_RESULT},
		'{ROW_TICK,  REG_TARGET,  16'h7FFF, S0,           1'b1, '{16'd0, CS_LOW, 1'b1}},
		// crossed clamp: max is tested first
		'{ROW_WRITE, REG_OUT_MIN, 16'd20000, 32'd0,       1'b0, ANY_RESULT},
		'{ROW_WRITE, REG_OUT_MAX, 16'd10000, 32'd0,       1'b0, ANY_RESULT},
		'{ROW_TICK,  REG_TARGET,  16'h8000, S0,           1'b1, '{16'd20000, CS_LOW, 1'b1}},
		'{ROW_WRITE, REG_TARGET,  16'h7FFF, 32'd0,        1'b0, ANY_RESULT},
		'{ROW_TICK,  REG_TARGET,  16'h8000, S0,           1'b1, '{16'd10000, CS_HIGH, 1'b1}},
		// clamp values past 1.0 are taken as written
		'{ROW_WRITE, REG_OUT_MIN, 16'hFFFF, 32'd0,        1'b0, ANY_RESULT},
		'{ROW_WRITE, REG_OUT_MAX, 16'hFFFF, 32'd0,        1'b0, ANY_RESULT},
		'{ROW_TICK,  REG_TARGET,  16'h8000, S0,           1'b1, '{16'hFFFF, CS_HIGH, 1'b1}},
		'{ROW_TICK,  REG_TARGET,  16'h7FFF, S0,           1'b1, '{16'hFFFF, CS_LOW, 1'b1}},
		// writes past the map must leave gain_i at zero
		'{ROW_WRITE, REG_SPARE6,  16'h1234, 32'd0,        1'b0, ANY_RESULT},
		'{ROW_WRITE, REG_SPARE7,  16'h7FFF, 32'd0,        1'b0, ANY_RESULT},
		'{ROW_WRITE, REG_OUT_MIN, 16'd0,    32'd0,        1'b0, ANY_RESULT},
		'{ROW_WRITE, REG_OUT_MAX, 16'd32768, 32'd0,       1'b0, ANY_RESULT},
		'{ROW_TICK,  REG_TARGET,  16'h7FFF, S0,           1'b1, '{16'd0, CS_WITHIN, 1'b1}},
		'{ROW_WRITE, REG_GAIN_P,  16'd410,  32'd0,        1'b0, ANY_RESULT},
		'{ROW_WRITE, REG_GAIN_I,  16'd41,   32'd0,        1'b0, ANY_RESULT},
		'{ROW_WRITE, REG_GAIN_D,  16'hFFFF, 32'd0,        1'b0, ANY_RESULT},
		'{ROW_WRITE, REG_TARGET,  16'h0000, 32'd0,        1'b0, ANY_RESULT},
		// one-tick intervals with full speed swings, then stamp wrap
		'{ROW_TICK,  REG_TARGET,  16'h8000, S0 + 32'd1,   1'b0, ANY_RESULT},
		'{ROW_TICK,  REG_TARGET,  16'h7FFF, S0 + 32'd2,   1'b0, ANY_RESULT},
		'{ROW_TICK,  REG_TARGET,  16'h0000, S0 + 32'd2,   1'b0, ANY_RESULT},
		'{ROW_TICK,  REG_TARGET,  16'h03E8, 32'h0000_0005, 1'b0, ANY_RESULT},
		'{ROW_TICK,  REG_TARGET,  16'hFC18, 32'hFFFF_FFFF, 1'b0, ANY_RESULT},
		'{ROW_TICK,  REG_TARGET,  16'h0000, 32'h0000_0290, 1'b0, ANY_RESULT},
		'{ROW_TICK,  REG_TARGET,  16'h00FF, 32'h0000_0291, 1'b0, ANY_RESULT},
		'{ROW_WRITE, REG_GAIN_D,  16'd41,   32'd0,        1'b0, ANY_RESULT}
	};

	pid_speed_controller_clamped #(
		.TIME_FRAC_BITS(TIME_FRAC),
		.INTEGRAL_WIDTH(INTEG_W)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// gain times operand, saturated once the operand passes 2^44
	function automatic longint gain_product(input logic [15:0] g, input longint x);
		if (g == 16'd0)
			return 0;
		if (x > FACTOR_LIM)
			return PROD_LIM;
		if (x < -FACTOR_LIM)
			return -PROD_LIM;
		return longint'({48'd0, g}) * x;
	endfunction

	// One control tick: updates the loop state and returns the PWM result.
	function automatic pwm_result_t predict_pwm(input logic signed [15:0] speed,
			input logic [31:0] stamp);
		pwm_result_t res;
		logic [31:0] dt32;
		longint      dt, err, acc, deriv, sum, lvl;
		dt32 = stamp - ctl_prev_stamp;
		dt = longint'({32'd0, dt32});
		err = longint'(set_target) - longint'(speed);
		// integral step is floored, then saturated to the integral width
		acc = ctl_integral + ((err * dt) >>> TIME_FRAC);
		if (acc > INT_HI)
			acc = INT_HI;
		else if (acc < INT_LO)
			acc = INT_LO;
		res.zero = (dt == 0);
		// derivative rounds toward zero, forced to zero on a zero interval
		deriv = (dt == 0) ? 0 : ((err - ctl_prev_err) * TICK_SCALE) / dt;
		sum = gain_product(set_kp, err) + gain_product(set_ki, acc)
			+ gain_product(set_kd, deriv);
		lvl = sum >>> 5;
		res.cs = CS_WITHIN;
		if (lvl > longint'({48'd0, set_out_max})) begin
			lvl = longint'({48'd0, set_out_max});
			res.cs = CS_HIGH;
		end else if (lvl < longint'({48'd0, set_out_min})) begin
			lvl = longint'({48'd0, set_out_min});
			res.cs = CS_LOW;
		end
		res.level = lvl[15:0];
		ctl_integral = acc;
		ctl_prev_err = err;
		ctl_prev_stamp = stamp;
		return res;
	endfunction

	function automatic logic [15:0] pick_gain();
		case ($urandom_range(4))
			0: return 16'd0;
			1: return 16'hFFFF;
			4: return 16'($urandom_range(0, 65535));
			default: return 16'($urandom_range(0, 600));
		endcase
	endfunction

	// register write on the cfg channel; the local copy follows the accepted request
	task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_TARGET:  set_target = data;
			REG_GAIN_P:  set_kp = data;
			REG_GAIN_I:  set_ki = data;
			REG_GAIN_D:  set_kd = data;
			REG_OUT_MIN: set_out_min = data;
			REG_OUT_MAX: set_out_max = data;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// drop the tick request and wait until every result is back
	task automatic wait_quiet();
		s_axis_tvalid <= 1'b0;
		while (pending_pwm.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic send_tick(input logic [15:0] speed, input logic [31:0] stamp,
			input bit typed, input pwm_result_t want);
		pwm_result_t got;
		// now and then a long gap so idle time lands on any part of the computation
		if (src_idle_pct != 0 && $urandom_range(7) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 60)) @(negedge clk);
		end
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {stamp, speed};
		do @(posedge clk); while (!s_axis_tready);
		got = predict_pwm(speed, stamp);
		pending_pwm.push_back(typed ? want : got);
		@(negedge clk);
	endtask

	task automatic choose_settings();
		logic [15:0] v;
		case ($urandom_range(3))
			0: v = 16'h8000;
			1: v = 16'h7FFF;
			default: v = 16'($urandom_range(0, 4096)) - 16'd2048;
		endcase
		apply_reg(REG_TARGET, v);
		apply_reg(REG_GAIN_P, pick_gain());
		apply_reg(REG_GAIN_I, pick_gain());
		apply_reg(REG_GAIN_D, pick_gain());
		// out_min may land above out_max
		case ($urandom_range(3))
			0: v = 16'd0;
			1: v = 16'($urandom_range(0, 32768));
			default: v = 16'($urandom_range(0, 8192));
		endcase
		apply_reg(REG_OUT_MIN, v);
		case ($urandom_range(3))
			0: v = 16'd32768;
			1: v = 16'hFFFF;
			default: v = 16'($urandom_range(16384, 32768));
		endcase
		apply_reg(REG_OUT_MAX, v);
	endtask

	// Result side: ready toggles per stall percentage; a hold request forces
	// ready low for HOLD_CYCLES so the controller backs up into s_axis.
	always @(negedge clk) begin
		if (hold_seen != hold_reqs) begin
			hold_seen = hold_reqs;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	// result checker: oldest pending result against each accepted request
	always @(posedge clk) begin
		pwm_result_t exp_res;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_pwm.size() == 0) begin
				$error("unexpected result: pwm_level %0d clamp_state %0d zero_interval %0d",
					m_axis_tdata, m_axis_tuser[1:0], m_axis_tuser[2]);
				fail_count = fail_count + 1;
			end else begin
				exp_res = pending_pwm.pop_front();
				if (m_axis_tdata !== exp_res.level) begin
					$error("pwm_level: expected %0d, actual %0d", exp_res.level, m_axis_tdata);
					fail_count = fail_count + 1;
				end
				if (m_axis_tuser[1:0] !== exp_res.cs) begin
					$error("clamp_state: expected %0d, actual %0d", exp_res.cs,
						m_axis_tuser[1:0]);
					fail_count = fail_count + 1;
				end
				if (m_axis_tuser[2] !== exp_res.zero) begin
					$error("zero_interval: expected %0d, actual %0d", exp_res.zero,
						m_axis_tuser[2]);
					fail_count = fail_count + 1;
				end
			end
		end
	end

	initial begin
		logic [15:0] spd;
		logic [31:0] gap;
		int          pick;
		int          guard;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_TARGET;
		cfg_data = '0;
		src_idle_pct = 0;
		sink_stall_pct = 0;
		hold_reqs = 0;
		hold_seen = 0;
		hold_left = 0;
		fail_count = 0;
		// register reset values, loop state cleared
		set_target = 16'sd0;
		set_kp = 16'd410;
		set_ki = 16'd41;
		set_kd = 16'd41;
		set_out_min = 16'd0;
		set_out_max = 16'd32768;
		ctl_prev_err = 0;
		ctl_integral = 0;
		ctl_prev_stamp = 32'd0;

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// directed table, no idling
		foreach (dir_rows[r]) begin
			if (dir_rows[r].kind == ROW_WRITE) begin
				wait_quiet();
				apply_reg(dir_rows[r].idx, dir_rows[r].val);
			end else begin
				send_tick(dir_rows[r].val, dir_rows[r].stamp, dir_rows[r].typed,
					dir_rows[r].want);
			end
		end

		// random ticks: four idling phases, three register settings each
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
				1: begin src_idle_pct = 61; sink_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  sink_stall_pct = 61; end
				default: begin src_idle_pct = 25; sink_stall_pct = 25; end
			endcase
			for (int s = 0; s < 3; s++) begin
				wait_quiet();
				choose_settings();
				// long hold-off on the result side while ticks keep coming
				if (ph == 0 && s == 1)
					hold_reqs = hold_reqs + 1;
				for (int n = 0; n < 55; n++) begin
					// mostly near the target, with extremes and full-range values
					case ($urandom_range(9))
						0: spd = 16'h8000;
						1: spd = 16'h7FFF;
						2: spd = 16'($urandom);
						default: spd = set_target + 16'($urandom_range(0, 1024)) - 16'd512;
					endcase
					// mostly ~100 Hz intervals; zero, one, wrap-size and full-range too
					pick = $urandom_range(39);
					if (pick < 2)
						gap = 32'd0;
					else if (pick == 2)
						gap = 32'd1;
					else if (pick == 3)
						gap = 32'hFFFF_FFFF;
					else if (pick == 4)
						gap = $urandom;
					else if (pick < 15)
						gap = $urandom_range(1, 64);
					else
						gap = $urandom_range(300, 1300);
					send_tick(spd, ctl_prev_stamp + gap, 1'b0, ANY_RESULT);
				end
			end
		end

		// Integrator windup: max error over the longest interval grows the
		// integral by about 2^32 per tick, then drives it back negative.
		src_idle_pct = 0;
		sink_stall_pct = 0;
		wait_quiet();
		apply_reg(REG_GAIN_P, 16'd0);
		apply_reg(REG_GAIN_I, 16'hFFFF);
		apply_reg(REG_GAIN_D, 16'd0);
		apply_reg(REG_OUT_MIN, 16'd0);
		apply_reg(REG_OUT_MAX, 16'hFFFF);
		apply_reg(REG_TARGET, 16'h7FFF);
		repeat (20)
			send_tick(16'h8000 + 16'($urandom_range(0, 2767)), ctl_prev_stamp - 32'd1,
				1'b0, ANY_RESULT);
		wait_quiet();
		apply_reg(REG_TARGET, 16'h8000);
		repeat (40)
			send_tick(16'h7FFF - 16'($urandom_range(0, 2767)), ctl_prev_stamp - 32'd1,
				1'b0, ANY_RESULT);

		// drain
		s_axis_tvalid <= 1'b0;
		guard = 0;
		while (pending_pwm.size() != 0 && guard < 100000) begin
			@(negedge clk);
			guard = guard + 1;
		end
		if (pending_pwm.size() != 0) begin
			$error("%0d results never arrived", pending_pwm.size());
			fail_count = fail_count + 1;
		end
		repeat (LATENCY + 20) @(negedge clk);
		if (fail_count == 0)
			$display("pid_speed_controller_clamped verification clean");
		else
			$display("pid_speed_controller_clamped verification failed");
		$finish;
	end

	// hang guard, several times the slowest expected run
	initial begin
		#40_000_000;
		$display("pid_speed_controller_clamped verification failed");
		$finish;
	end

endmodule
